FILE: rtl/framebuffer_pixel_format_converter_macros.svh
// Assertion macros shared by the pixel format converter RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef FRAMEBUFFER_PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define FRAMEBUFFER_PIXEL_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBPFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBPFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fbpfc_pkg.sv
// Types and constants of the framebuffer pixel format converter.
// No dependencies.
`default_nettype none

package fbpfc_pkg;

    localparam int COL_W       = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_I1         = 3'd0,
        MODE_I2         = 3'd1,
        MODE_I4         = 3'd2,
        MODE_I8         = 3'd3,
        MODE_RGB16      = 3'd4,
        MODE_RGB16_SWAP = 3'd5,
        MODE_RGB24      = 3'd6,
        MODE_RGB32      = 3'd7
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_MODE = 3'd0,
        REG_ROW_WIDTH   = 3'd1,
        REG_RED_MASK    = 3'd2,
        REG_GREEN_MASK  = 3'd3,
        REG_BLUE_MASK   = 3'd4,
        REG_RED_SHIFT   = 3'd5,
        REG_GREEN_SHIFT = 3'd6,
        REG_BLUE_SHIFT  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_PALETTE = 2'd0,
        KIND_INDEXED = 2'd1,
        KIND_DIRECT  = 2'd2
    } kind_t;

    localparam logic ACTION_PALETTE = 1'b0;

    typedef struct packed {
        mode_t              source_mode;
        logic [COL_W-1:0]   row_width;
        logic [15:0]        red_mask;
        logic [15:0]        green_mask;
        logic [15:0]        blue_mask;
        logic [4:0]         red_shift;
        logic [4:0]         green_shift;
        logic [4:0]         blue_shift;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        source_mode: MODE_I8,
        row_width:   13'd4096,
        red_mask:    16'hf800,
        green_mask:  16'h07e0,
        blue_mask:   16'h001f,
        red_shift:   5'd16,
        green_shift: 5'd8,
        blue_shift:  5'd0
    };

    // idx holds the palette index of a write or the packed byte of an indexed item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  idx;
        logic [23:0] color;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/fbpfc_if.sv
// Request channel interfaces of the pixel format converter.
// No dependencies.
`default_nettype none

interface fbpfc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [31:0] source_data;

    modport source (output valid, action, palette_index, palette_color, source_data,
                    input ready);
    modport sink (input valid, action, palette_index, palette_color, source_data,
                  output ready);
endinterface

interface fbpfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_item;
    logic       row_end;

    modport source (output valid, red, green, blue, last_of_item, row_end, input ready);
    modport sink (input valid, red, green, blue, last_of_item, row_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/fbpfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fbpfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/fbpfc_front.sv
// Front end: accepts requests, classifies them and converts direct-colour pixels.
// Depends on fbpfc_pkg and fbpfc_in_if.
`default_nettype none

module fbpfc_front (
    input  fbpfc_pkg::cfg_t   cfg,
    fbpfc_in_if.sink          words,
    output logic              push_valid,
    output fbpfc_pkg::entry_t push_entry,
    input  logic              push_ready
);

    import fbpfc_pkg::*;

    localparam logic [15:0] MASK_R565 = 16'hf800;
    localparam logic [15:0] MASK_R555 = 16'h7c00;
    localparam logic [15:0] MASK_G565 = 16'h07e0;
    localparam logic [15:0] MASK_G555 = 16'h03e0;
    localparam logic [15:0] MASK_B5   = 16'h001f;

    localparam logic [4:0] ORDER_RGB = 5'd0;
    localparam logic [4:0] ORDER_RBG = 5'd1;
    localparam logic [4:0] ORDER_GBR = 5'd2;
    localparam logic [4:0] ORDER_GRB = 5'd3;
    localparam logic [4:0] ORDER_BGR = 5'd4;
    localparam logic [4:0] ORDER_BRG = 5'd5;

    function automatic logic [7:0] expand16(input logic [15:0] mask, input logic [15:0] v);
        logic [7:0] c;
        case (mask)
            MASK_R565: c = {v[15:11], v[15:13]};
            MASK_R555: c = {v[14:10], v[14:12]};
            MASK_G565: c = {v[10:5], v[10:9]};
            MASK_G555: c = {v[9:5], v[9:7]};
            MASK_B5:   c = {v[4:0], v[4:2]};
            default:   c = v[7:0];
        endcase
        return c;
    endfunction

    logic [15:0] pix16;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [31:0] red32;
    logic [31:0] green32;
    logic [31:0] blue32;
    logic [23:0] direct_color;

    assign byte0   = words.source_data[7:0];
    assign byte1   = words.source_data[15:8];
    assign byte2   = words.source_data[23:16];
    assign pix16   = (cfg.source_mode == MODE_RGB16_SWAP) ? {byte0, byte1} : {byte1, byte0};
    assign red32   = words.source_data >> cfg.red_shift;
    assign green32 = words.source_data >> cfg.green_shift;
    assign blue32  = words.source_data >> cfg.blue_shift;

    always_comb
    begin
        case (cfg.source_mode)
            MODE_RGB16, MODE_RGB16_SWAP:
            begin
                direct_color = {expand16(cfg.red_mask, pix16), expand16(cfg.green_mask, pix16),
                                expand16(cfg.blue_mask, pix16)};
            end
            MODE_RGB24:
            begin
                case (cfg.red_shift)
                    ORDER_RGB: direct_color = {byte0, byte1, byte2};
                    ORDER_RBG: direct_color = {byte0, byte2, byte1};
                    ORDER_GBR: direct_color = {byte1, byte2, byte0};
                    ORDER_GRB: direct_color = {byte1, byte0, byte2};
                    ORDER_BGR: direct_color = {byte2, byte1, byte0};
                    ORDER_BRG: direct_color = {byte2, byte0, byte1};
                    default:   direct_color = {byte0, byte1, byte2};
                endcase
            end
            default:
            begin
                direct_color = {red32[7:0], green32[7:0], blue32[7:0]};
            end
        endcase
    end

    always_comb
    begin
        push_entry.idx = byte0;
        if (words.action == ACTION_PALETTE)
        begin
            push_entry.kind  = KIND_PALETTE;
            push_entry.idx   = words.palette_index;
            push_entry.color = words.palette_color;
        end
        else if (cfg.source_mode inside {MODE_I1, MODE_I2, MODE_I4, MODE_I8})
        begin
            push_entry.kind  = KIND_INDEXED;
            push_entry.color = direct_color;
        end
        else
        begin
            push_entry.kind  = KIND_DIRECT;
            push_entry.color = direct_color;
        end
    end

    assign push_valid  = words.valid;
    assign words.ready = push_ready;

endmodule

`default_nettype wire

FILE: rtl/fbpfc_queue.sv
// Short request queue between the front and back ends.
// Depends on fbpfc_pkg.
`default_nettype none

module fbpfc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  fbpfc_pkg::entry_t push_entry,
    output logic              push_ready,
    output logic              head_valid,
    output fbpfc_pkg::entry_t head,
    input  logic              pop
);

    import fbpfc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fbpfc_back.sv
// Back end: palette writes, packed pixel unpacking, palette lookup, row tracking.
// Depends on fbpfc_pkg, fbpfc_out_if, fbpfc_ram and the assertion macros.
`default_nettype none
`include "framebuffer_pixel_format_converter_macros.svh"

module fbpfc_back #(
    parameter int MAX_WIDTH     = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fbpfc_pkg::cfg_t   cfg,
    input  fbpfc_pkg::entry_t head,
    input  logic              head_valid,
    output logic              pop,
    fbpfc_out_if.source       pixels
);

    import fbpfc_pkg::*;

    localparam int          INDEX_W = $clog2(PALETTE_DEPTH);
    localparam logic [16:0] MAX_W   = 17'(MAX_WIDTH);

    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] column_next;
    logic [2:0]       pix_reg;
    logic [2:0]       pix_next;
    logic             s2_valid_reg;
    logic             s2_valid_next;
    logic             s2_lookup_reg;
    logic             s2_zero_reg;
    logic [23:0]      s2_color_reg;
    logic             s2_last_reg;
    logic             s2_row_end_reg;

    logic [COL_W-1:0] eff_width;
    logic             row_end;
    logic [2:0]       ppb_m1;
    logic [3:0]       shift_amt;
    logic [7:0]       shifted;
    logic [7:0]       pixel_idx;
    logic             s2_ready;
    logic             issue_px;
    logic             item_done;
    logic             pal_we;
    logic [23:0]      ram_rdata;

    always_comb
    begin
        if (cfg.row_width == '0)
        begin
            eff_width = COL_W'(1);
        end
        else if (17'(cfg.row_width) > MAX_W)
        begin
            eff_width = MAX_W[COL_W-1:0];
        end
        else
        begin
            eff_width = cfg.row_width;
        end
    end

    assign row_end = ((COL_W + 1)'(column_reg) + 1'b1) >= (COL_W + 1)'(eff_width);

    always_comb
    begin
        case (cfg.source_mode)
            MODE_I1: ppb_m1 = 3'd7;
            MODE_I2: ppb_m1 = 3'd3;
            MODE_I4: ppb_m1 = 3'd1;
            default: ppb_m1 = 3'd0;
        endcase
    end

    assign shift_amt = 4'(pix_reg) << cfg.source_mode[1:0];
    assign shifted   = 8'(head.idx << shift_amt);

    always_comb
    begin
        case (cfg.source_mode)
            MODE_I1: pixel_idx = {7'b0, shifted[7]};
            MODE_I2: pixel_idx = {6'b0, shifted[7:6]};
            MODE_I4: pixel_idx = {4'b0, shifted[7:4]};
            default: pixel_idx = shifted;
        endcase
    end

    assign s2_ready = !s2_valid_reg || pixels.ready;

    always_comb
    begin
        issue_px  = 1'b0;
        item_done = 1'b1;
        pal_we    = 1'b0;
        pop       = 1'b0;
        case (head.kind)
            KIND_PALETTE:
            begin
                pal_we = head_valid && ({1'b0, head.idx} < 9'(PALETTE_DEPTH));
                pop    = head_valid;
            end
            KIND_INDEXED:
            begin
                issue_px  = head_valid && s2_ready;
                item_done = row_end || (pix_reg == ppb_m1);
                pop       = issue_px && item_done;
            end
            KIND_DIRECT:
            begin
                issue_px = head_valid && s2_ready;
                pop      = issue_px;
            end
            default:
            begin
                pop = head_valid;
            end
        endcase
    end

    always_comb
    begin
        pix_next      = pix_reg;
        column_next   = column_reg;
        s2_valid_next = s2_valid_reg;
        if (issue_px)
        begin
            pix_next    = item_done ? 3'd0 : pix_reg + 3'd1;
            column_next = row_end ? '0 : column_reg + 1'b1;
        end
        if (s2_ready)
        begin
            s2_valid_next = issue_px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            pix_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            pix_reg      <= pix_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_px)
        begin
            s2_lookup_reg  <= (head.kind == KIND_INDEXED);
            s2_zero_reg    <= ({1'b0, pixel_idx} >= 9'(PALETTE_DEPTH));
            s2_color_reg   <= head.color;
            s2_last_reg    <= item_done;
            s2_row_end_reg <= row_end;
        end
    end

    fbpfc_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (head.idx[INDEX_W-1:0]),
        .wdata (head.color),
        .re    (issue_px),
        .raddr (pixel_idx[INDEX_W-1:0]),
        .rdata (ram_rdata)
    );

    logic [23:0] out_color;

    always_comb
    begin
        if (!s2_lookup_reg)
        begin
            out_color = s2_color_reg;
        end
        else if (s2_zero_reg)
        begin
            out_color = '0;
        end
        else
        begin
            out_color = ram_rdata;
        end
    end

    assign pixels.valid        = s2_valid_reg;
    assign pixels.red          = out_color[23:16];
    assign pixels.green        = out_color[15:8];
    assign pixels.blue         = out_color[7:0];
    assign pixels.last_of_item = s2_last_reg;
    assign pixels.row_end      = s2_row_end_reg;

    `FBPFC_ASSERT_SAME(a_indexed_pop_done, pop && head.kind == KIND_INDEXED,
        issue_px && item_done, "indexed item left before its last pixel")
    `FBPFC_ASSERT_NEXT(a_row_end_clears, issue_px && row_end,
        column_reg == '0 && pix_reg == '0, "row end did not restart column")
    `FBPFC_ASSERT_NEXT(a_stall_holds, s2_valid_reg && !pixels.ready,
        s2_valid_reg && $stable(s2_last_reg) && $stable(s2_row_end_reg),
        "stalled pixel lost its flags")
    `FBPFC_ASSERT_SAME(a_palette_no_pixel, head_valid && head.kind == KIND_PALETTE,
        !issue_px, "palette write issued a pixel")

endmodule

`default_nettype wire

FILE: rtl/framebuffer_pixel_format_converter.sv
// Top level of the framebuffer pixel format converter: configuration registers,
// front end, request queue and back end. Depends on fbpfc_pkg and all rtl modules.
//
//   channel     direction  payload
//   words       sink       action, palette_index, palette_color, source_data
//   pixels      source     red, green, blue, last_of_item, row_end
//   cfg_*       write      cfg_index selects the register, cfg_data its value
//
// Direct-colour and 8-bit indexed requests give one pixel per cycle while the output
// is not stalled; a packed byte gives one pixel per cycle (up to 8), set by the
// single palette read port. Requests are queued; pixels are registered at the output.
// Reset clears column count and queue and restores the register defaults; the palette
// is not cleared.
// The four-entry queue lets the front accept, until full, while the output stalls.
`default_nettype none

module framebuffer_pixel_format_converter #(
    parameter int MAX_WIDTH     = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    fbpfc_in_if.sink                               words,
    fbpfc_out_if.source                            pixels,
    input  logic                                   cfg_write_en,
    input  logic [fbpfc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fbpfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import fbpfc_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;
    logic   head_valid;
    entry_t head;
    logic   pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SOURCE_MODE: cfg_next.source_mode = mode_t'(cfg_data[2:0]);
                REG_ROW_WIDTH:   cfg_next.row_width   = cfg_data[COL_W-1:0];
                REG_RED_MASK:    cfg_next.red_mask    = cfg_data;
                REG_GREEN_MASK:  cfg_next.green_mask  = cfg_data;
                REG_BLUE_MASK:   cfg_next.blue_mask   = cfg_data;
                REG_RED_SHIFT:   cfg_next.red_shift   = cfg_data[4:0];
                REG_GREEN_SHIFT: cfg_next.green_shift = cfg_data[4:0];
                REG_BLUE_SHIFT:  cfg_next.blue_shift  = cfg_data[4:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fbpfc_front u_front (
        .cfg        (cfg_reg),
        .words      (words),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    fbpfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    fbpfc_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .pixels     (pixels)
    );

endmodule

`default_nettype wire

FILE: test/tb_framebuffer_pixel_format_converter.sv
`timescale 1ns / 100ps
// Self-checking bench for the framebuffer pixel format converter: directed and random
// source words, palette loads and register settings against an in-bench pixel predictor.
// Depends on fbpfc_pkg, the channel interfaces in fbpfc_if.sv and the converter RTL.

module tb_framebuffer_pixel_format_converter;
    import fbpfc_pkg::*;

    localparam int MAX_WIDTH     = 4096;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int TIMEOUT_NS    = 4_000_000;

    localparam logic ACTION_PIXELS = 1'b1;

    localparam logic [15:0] MASK_565_RED   = 16'hf800;
    localparam logic [15:0] MASK_555_RED   = 16'h7c00;
    localparam logic [15:0] MASK_565_GREEN = 16'h07e0;
    localparam logic [15:0] MASK_555_GREEN = 16'h03e0;
    localparam logic [15:0] MASK_BLUE      = 16'h001f;

    localparam logic [4:0] ORDER_RGB = 5'd0;
    localparam logic [4:0] ORDER_RBG = 5'd1;
    localparam logic [4:0] ORDER_GBR = 5'd2;
    localparam logic [4:0] ORDER_GRB = 5'd3;
    localparam logic [4:0] ORDER_BGR = 5'd4;
    localparam logic [4:0] ORDER_BRG = 5'd5;

    typedef struct packed {
        logic        action;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
        logic [31:0] source_data;
    } word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_item;
        logic       row_end;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    fbpfc_in_if  words_if ();
    fbpfc_out_if pixels_if ();

    framebuffer_pixel_format_converter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .words        (words_if),
        .pixels       (pixels_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    word_t       pending_words[$];
    pixel_t      expected_pixels[$];
    cfg_t        shadow_cfg = CFG_RESET;
    logic [23:0] shadow_palette [256];
    bit          palette_loaded [256];
    int unsigned column_count = 0;
    int          failures = 0;
    int          sender_idle_pct = 0;
    int          receiver_idle_pct = 0;
    bit          hold_active = 1'b0;
    bit          word_taken = 1'b0;
    word_t       next_word;
    pixel_t      want;
    event        receiver_hold_go;

    always #2 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      bit final_in_item);
        int unsigned width;
        bit ends;
        pixel_t px;
        if (shadow_cfg.row_width == 0)
            width = 1;
        else if (shadow_cfg.row_width > MAX_WIDTH)
            width = MAX_WIDTH;
        else
            width = 32'(shadow_cfg.row_width);
        ends = (column_count + 1 >= width);
        column_count = ends ? 0 : column_count + 1;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.last_of_item = final_in_item || ends;
        px.row_end = ends;
        expected_pixels.push_back(px);
        return ends;
    endfunction

    function automatic logic [7:0] expand_channel(logic [15:0] mask, logic [15:0] v);
        logic [15:0] t;
        case (mask)
            MASK_565_RED:   t = ((v >> 8) & 16'h00f8) | (v >> 13);
            MASK_555_RED:   t = ((v >> 7) & 16'h00f8) | ((v >> 12) & 16'h0007);
            MASK_565_GREEN: t = ((v >> 3) & 16'h00fc) | ((v >> 9) & 16'h0003);
            MASK_555_GREEN: t = ((v >> 2) & 16'h00f8) | ((v >> 7) & 16'h0007);
            MASK_BLUE:      t = (v << 3) | ((v >> 2) & 16'h0007);
            default:        t = v;
        endcase
        return t[7:0];
    endfunction

    function automatic void predict_pixels(word_t w);
        int unsigned bpp;
        int unsigned per_byte;
        int unsigned pix_mask;
        int unsigned sh;
        logic [7:0]  idx;
        logic [23:0] color;
        logic [15:0] v;
        logic [7:0]  b0, b1, b2;
        logic [31:0] sr, sg, sb;
        bit ends;
        if (w.action == ACTION_PALETTE)
        begin
            shadow_palette[w.palette_index] = w.palette_color;
            return;
        end
        case (shadow_cfg.source_mode)
            MODE_I1, MODE_I2, MODE_I4, MODE_I8:
            begin
                bpp = 1 << shadow_cfg.source_mode;
                per_byte = 8 / bpp;
                pix_mask = (1 << bpp) - 1;
                for (int i = 0; i < per_byte; i++)
                begin
                    sh = 8 - bpp * (i + 1);
                    idx = 8'((w.source_data[7:0] >> sh) & pix_mask);
                    color = shadow_palette[idx];
                    ends = push_pixel(color[23:16], color[15:8], color[7:0],
                                      i == per_byte - 1);
                    if (ends)
                        break;
                end
            end
            MODE_RGB16, MODE_RGB16_SWAP:
            begin
                v = w.source_data[15:0];
                if (shadow_cfg.source_mode == MODE_RGB16_SWAP)
                    v = {v[7:0], v[15:8]};
                void'(push_pixel(expand_channel(shadow_cfg.red_mask, v),
                                 expand_channel(shadow_cfg.green_mask, v),
                                 expand_channel(shadow_cfg.blue_mask, v), 1'b1));
            end
            MODE_RGB24:
            begin
                b0 = w.source_data[7:0];
                b1 = w.source_data[15:8];
                b2 = w.source_data[23:16];
                case (shadow_cfg.red_shift)
                    ORDER_RBG: void'(push_pixel(b0, b2, b1, 1'b1));
                    ORDER_GBR: void'(push_pixel(b1, b2, b0, 1'b1));
                    ORDER_GRB: void'(push_pixel(b1, b0, b2, 1'b1));
                    ORDER_BGR: void'(push_pixel(b2, b1, b0, 1'b1));
                    ORDER_BRG: void'(push_pixel(b2, b0, b1, 1'b1));
                    default:   void'(push_pixel(b0, b1, b2, 1'b1));
                endcase
            end
            default:
            begin
                sr = w.source_data >> shadow_cfg.red_shift;
                sg = w.source_data >> shadow_cfg.green_shift;
                sb = w.source_data >> shadow_cfg.blue_shift;
                void'(push_pixel(sr[7:0], sg[7:0], sb[7:0], 1'b1));
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got);
        if (got !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got);
            failures++;
        end
    endfunction

    // request side: hold valid until taken, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n && (!words_if.valid || word_taken))
        begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_word = pending_words.pop_front();
                words_if.valid         <= 1'b1;
                words_if.action        <= next_word.action;
                words_if.palette_index <= next_word.palette_index;
                words_if.palette_color <= next_word.palette_color;
                words_if.source_data   <= next_word.source_data;
            end
            else
            begin
                words_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        word_taken <= words_if.valid && words_if.ready;
        if (rst_n && words_if.valid && words_if.ready)
            predict_pixels('{words_if.action, words_if.palette_index,
                             words_if.palette_color, words_if.source_data});
    end

    always
    begin
        @(receiver_hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    always @(negedge clk)
        pixels_if.ready <= rst_n && !hold_active && $urandom_range(0, 99) >= receiver_idle_pct;

    always @(posedge clk)
    begin
        if (rst_n && pixels_if.valid && pixels_if.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual %h%h%h last=%b end=%b",
                         $time, pixels_if.red, pixels_if.green, pixels_if.blue,
                         pixels_if.last_of_item, pixels_if.row_end);
                failures++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("red", want.red, pixels_if.red);
                check_field("green", want.green, pixels_if.green);
                check_field("blue", want.blue, pixels_if.blue);
                check_field("last_of_item", 8'(want.last_of_item), 8'(pixels_if.last_of_item));
                check_field("row_end", 8'(want.row_end), 8'(pixels_if.row_end));
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        case (idx)
            REG_SOURCE_MODE: shadow_cfg.source_mode = mode_t'(value[2:0]);
            REG_ROW_WIDTH:   shadow_cfg.row_width   = value[12:0];
            REG_RED_MASK:    shadow_cfg.red_mask    = value;
            REG_GREEN_MASK:  shadow_cfg.green_mask  = value;
            REG_BLUE_MASK:   shadow_cfg.blue_mask   = value;
            REG_RED_SHIFT:   shadow_cfg.red_shift   = value[4:0];
            REG_GREEN_SHIFT: shadow_cfg.green_shift = value[4:0];
            REG_BLUE_SHIFT:  shadow_cfg.blue_shift  = value[4:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || words_if.valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic void queue_palette_write(logic [7:0] idx, logic [23:0] color);
        palette_loaded[idx] = 1'b1;
        pending_words.push_back('{ACTION_PALETTE, idx, color, 32'($urandom)});
    endfunction

    function automatic void queue_source(logic [31:0] data);
        pending_words.push_back('{ACTION_PIXELS, 8'($urandom), 24'($urandom), data});
    endfunction

    function automatic logic [7:0] loaded_index(int unsigned bpp);
        logic [7:0] c;
        repeat (64)
        begin
            c = 8'($urandom_range(0, (1 << bpp) - 1));
            if (palette_loaded[c])
                return c;
        end
        return 8'd0;
    endfunction

    function automatic logic [31:0] random_packed_word();
        int unsigned bpp;
        logic [7:0] packed_byte;
        bpp = 1 << shadow_cfg.source_mode;
        packed_byte = 8'd0;
        for (int i = 0; i < 8 / bpp; i++)
            packed_byte = 8'((packed_byte << bpp) | loaded_index(bpp));
        return {24'($urandom), packed_byte};
    endfunction

    function automatic logic [15:0] random_mask();
        case ($urandom_range(0, 6))
            0: return MASK_565_RED;
            1: return MASK_555_RED;
            2: return MASK_565_GREEN;
            3: return MASK_555_GREEN;
            4: return MASK_BLUE;
            5: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        logic [15:0] width;
        case ($urandom_range(0, 9))
            0: width = 16'd0;
            1: width = 16'(MAX_WIDTH);
            2: width = 16'd8191;
            3: width = 16'($urandom_range(1, 8191));
            default: width = 16'($urandom_range(1, 12));
        endcase
        write_reg(REG_SOURCE_MODE, 16'($urandom_range(0, 7)));
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_RED_MASK, random_mask());
        write_reg(REG_GREEN_MASK, random_mask());
        write_reg(REG_BLUE_MASK, random_mask());
        write_reg(REG_RED_SHIFT, $urandom_range(0, 1) ? 16'($urandom_range(0, 5))
                                                      : 16'($urandom_range(0, 31)));
        write_reg(REG_GREEN_SHIFT, 16'($urandom_range(0, 31)));
        write_reg(REG_BLUE_SHIFT, 16'($urandom_range(0, 31)));
    endtask

    initial
    begin : stimulus
        logic [4:0] order_codes [8];
        order_codes = '{ORDER_RGB, ORDER_RBG, ORDER_GBR, ORDER_GRB,
                        ORDER_BGR, ORDER_BRG, 5'd6, 5'd31};
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_SOURCE_MODE;
        cfg_data = '0;
        words_if.valid = 1'b0;
        words_if.action = ACTION_PALETTE;
        words_if.palette_index = '0;
        words_if.palette_color = '0;
        words_if.source_data = '0;
        pixels_if.ready = 1'b0;
        for (int i = 0; i < 256; i++)
        begin
            shadow_palette[i] = '0;
            palette_loaded[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 38;
        receiver_idle_pct = 69;

        queue_palette_write(8'd0, 24'h000000);
        queue_palette_write(8'd1, 24'hffffff);
        queue_palette_write(8'd2, 24'h5a3c96);
        queue_palette_write(8'd3, 24'ha5c369);
        queue_palette_write(8'd255, 24'h123456);
        queue_source(32'hffffff00);
        queue_source(32'h000000ff);
        queue_source(32'h80000001);
        wait_idle();

        // row ends inside a packed byte
        write_reg(REG_SOURCE_MODE, MODE_I1);
        write_reg(REG_ROW_WIDTH, 16'd5);
        queue_source(32'h000000ff);
        queue_source(32'hffffff81);
        wait_idle();

        write_reg(REG_SOURCE_MODE, MODE_I2);
        write_reg(REG_ROW_WIDTH, 16'd0);
        queue_source(32'h000000e4);
        wait_idle();

        write_reg(REG_SOURCE_MODE, MODE_I4);
        write_reg(REG_ROW_WIDTH, 16'd8191);
        queue_source(32'h00000032);
        queue_source(32'h00000010);
        wait_idle();

        write_reg(REG_ROW_WIDTH, 16'(MAX_WIDTH));
        write_reg(REG_SOURCE_MODE, MODE_RGB16);
        queue_source(32'hffff0000);
        queue_source(32'h0000ffff);
        wait_idle();
        write_reg(REG_SOURCE_MODE, MODE_RGB16_SWAP);
        queue_source(32'h00001234);
        wait_idle();
        write_reg(REG_SOURCE_MODE, MODE_RGB16);
        write_reg(REG_RED_MASK, MASK_555_RED);
        write_reg(REG_GREEN_MASK, MASK_555_GREEN);
        write_reg(REG_BLUE_MASK, 16'h0000);
        queue_source(32'h0000a5c3);
        wait_idle();

        write_reg(REG_SOURCE_MODE, MODE_RGB24);
        foreach (order_codes[i])
        begin
            write_reg(REG_RED_SHIFT, 16'(order_codes[i]));
            queue_source(32'hffa1b2c3);
            wait_idle();
        end

        write_reg(REG_SOURCE_MODE, MODE_RGB32);
        write_reg(REG_RED_SHIFT, 16'd31);
        write_reg(REG_GREEN_SHIFT, 16'd0);
        write_reg(REG_BLUE_SHIFT, 16'd24);
        queue_source(32'hffffffff);
        queue_source(32'h81234567);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            if (p == 4)
            begin
                sender_idle_pct = 69;
                receiver_idle_pct = 38;
            end
            else if (p == 7)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            randomize_config();
            if (p == 0)
            begin
                for (int i = 4; i < 16; i++)
                    queue_palette_write(8'(i), 24'($urandom));
                repeat (12)
                    queue_palette_write(8'($urandom), 24'($urandom));
            end
            else
            begin
                repeat (25)
                begin
                    if ($urandom_range(0, 99) < 15)
                        queue_palette_write(8'($urandom), 24'($urandom));
                    else if (shadow_cfg.source_mode <= MODE_I8)
                        queue_source(random_packed_word());
                    else
                        queue_source($urandom);
                end
            end
            // back up the output so the queue fills and the input stalls
            if (p == 8)
                -> receiver_hold_go;
            wait_idle();
        end

        if (expected_pixels.size() != 0)
        begin
            $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
            failures++;
        end
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/fbpfc_pkg.sv
rtl/fbpfc_if.sv
rtl/fbpfc_ram.sv
rtl/fbpfc_front.sv
rtl/fbpfc_queue.sv
rtl/fbpfc_back.sv
rtl/framebuffer_pixel_format_converter.sv
test/tb_framebuffer_pixel_format_converter.sv
